FILE: hw/rtl/adsr_envelope_crossfade_assert.svh
// ----------------------------------------------------------------------------
// adsr envelope crossfade assertion macros
// concurrent property wrappers shared by the envelope rtl
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_CROSSFADE_ASSERT_SVH
`define ADSR_ENVELOPE_CROSSFADE_ASSERT_SVH

// same-cycle implication
`define ADSRXF_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ADSRXF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/adsrxf_pkg.sv
// ----------------------------------------------------------------------------
// adsrxf_pkg
// widths, command codes and fixed-point constants of the envelope block
// ----------------------------------------------------------------------------
`default_nettype none

package adsrxf_pkg;

  localparam int FRAME_W   = 32;
  localparam int TIME_W    = 24;
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = SAMPLE_W - 1;
  localparam int FADE_W    = 16;
  localparam int CNT_W     = FADE_W + 1;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_TICK      = 2'd0;
  localparam cmd_t CMD_FULL      = 2'd1;
  localparam cmd_t CMD_START_AMP = 2'd2;
  localparam cmd_t CMD_START     = 2'd3;

  localparam logic [SAMPLE_W-1:0] ONE_Q      = SAMPLE_W'(1 << FRAC_W);
  localparam logic [FADE_W-1:0]   FADE_RESET = FADE_W'(100);

  // quotients never exceed one in q1.15, so 17 quotient bits suffice
  localparam int DIV_STEPS = FRAC_W + 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DVD_W     = TIME_W + FRAC_W + 1;

  localparam int MUL_A_W   = TIME_W + 1;
  localparam int MUL_B_W   = CNT_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = SAMPLE_W + CNT_W + 1;

endpackage

`default_nettype wire

FILE: hw/rtl/adsr_envelope_crossfade.sv
// ----------------------------------------------------------------------------
// adsr_envelope_crossfade
// frame-timed adsr envelope with retrigger crossfade, q1.15 floor rounding
//
//   port group   direction  handshake          content
//   in_*         input      in_valid/in_stall   command word with frame and params
//   out_*        output     out_valid/out_stall level, in_envelope, crossfading
//   cfg_*        input      cfg_we              crossfade length
//
// a retrigger word is taken in the idle state and gives no result
// a tick outside the envelope or in sustain skips the divider; attack, decay
// and release each run a 17-step restoring divide on the shared subtractor,
// and a blend runs another one
// the one shared multiplier registers each product
// reset is synchronous and needs no clearing pass
// out_stall holds the finished tick in its final state until the slot frees
// ----------------------------------------------------------------------------
`default_nettype none

`include "adsr_envelope_crossfade_assert.svh"

module adsr_envelope_crossfade (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire adsrxf_pkg::cmd_t                        in_command,
  input  wire logic [adsrxf_pkg::FRAME_W-1:0]          in_frame,
  input  wire logic [adsrxf_pkg::TIME_W-1:0]           in_attack_time,
  input  wire logic [adsrxf_pkg::TIME_W-1:0]           in_decay_time,
  input  wire logic [adsrxf_pkg::SAMPLE_W-1:0]         in_sustain,
  input  wire logic [adsrxf_pkg::TIME_W-1:0]           in_release_time,
  input  wire logic [adsrxf_pkg::FRAME_W-1:0]          in_start_time,
  input  wire logic [adsrxf_pkg::TIME_W-1:0]           in_note_length,
  input  wire logic signed [adsrxf_pkg::SAMPLE_W-1:0]  in_amplitude,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [adsrxf_pkg::SAMPLE_W-1:0]       out_level,
  output logic                                         out_in_envelope,
  output logic                                         out_crossfading,
  input  wire logic                                    cfg_we,
  input  wire logic [adsrxf_pkg::FADE_W-1:0]           cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PHASE = 4'd1;
  localparam logic [3:0] S_MW    = 4'd2;
  localparam logic [3:0] S_NSUM  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DDONE = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_SW    = 4'd7;
  localparam logic [3:0] S_VAL   = 4'd8;
  localparam logic [3:0] S_B2    = 4'd9;
  localparam logic [3:0] S_B3    = 4'd10;
  localparam logic [3:0] S_B4    = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam int FW = adsrxf_pkg::FRAME_W;
  localparam int TW = adsrxf_pkg::TIME_W;
  localparam int SW = adsrxf_pkg::SAMPLE_W;
  localparam int QW = adsrxf_pkg::FRAC_W;
  localparam int LW = adsrxf_pkg::FADE_W;
  localparam int CW = adsrxf_pkg::CNT_W;
  localparam int NS = adsrxf_pkg::DIV_STEPS;
  localparam int DW = adsrxf_pkg::DVD_W;
  localparam int AW = adsrxf_pkg::MUL_A_W;
  localparam int BW = adsrxf_pkg::MUL_B_W;
  localparam int PW = adsrxf_pkg::PROD_W;
  localparam int XW = adsrxf_pkg::ACC_W;

  // control and envelope state
  logic [3:0]              state_r;
  logic [LW-1:0]           cfg_len_r;
  logic [TW-1:0]           att_r, dec_r, rel_r, note_r;
  logic [SW-1:0]           sus_r;
  logic [FW-1:0]           start_r;
  logic signed [SW-1:0]    gain_r;
  logic                    fade_act_r;
  logic [CW-1:0]           fade_cnt_r;
  logic signed [SW-1:0]    fade_from_r;
  logic signed [SW-1:0]    last_r;
  logic                    out_valid_r;

  // datapath
  logic [FW-1:0]           e_r;
  logic                    ge_r;
  logic                    inside_r;
  logic [TW-1:0]           tmp_r;
  logic signed [AW-1:0]    mul_a_r;
  logic signed [BW-1:0]    mul_b_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [XW-1:0]    acc_r;
  logic [TW-1:0]           div_rem_r;
  logic [NS-1:0]           div_dq_r;
  logic [TW-1:0]           div_den_r;
  logic [adsrxf_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic                    div_blend_r;
  logic                    neg_r;
  logic [SW-1:0]           env_r;
  logic signed [SW-1:0]    val_r;
  logic signed [SW-1:0]    out_level_r;
  logic                    out_in_env_r;
  logic                    out_xfade_r;

  // phase decode
  logic [TW:0]             span_w, ad_w, dec_rest_w, rel_rest_w;
  logic                    e_lt_span, e_lt_att, e_lt_ad, e_lt_note;
  logic [TW-1:0]           dec_k_w;
  logic [DW-1:0]           att_dvd_w, nsum_dvd_w, bl_dvd_w;

  // blend and divider
  logic                    blend_en;
  logic signed [XW-1:0]    num_w;
  logic [XW-1:0]           num_abs_w;
  logic [TW:0]             dstep_t, dstep_sub;
  logic                    dstep_ge;
  logic [NS-1:0]           q_adj_w, q_neg_w;
  logic [CW-1:0]           cnt_lim_w, cnt_cap_w, cnt_adv_w;
  logic signed [PW-1:0]    prod_w;
  logic                    in_acc, out_load;

  assign in_stall        = (state_r != S_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign out_load        = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign out_valid       = out_valid_r;
  assign out_level       = out_level_r;
  assign out_in_envelope = out_in_env_r;
  assign out_crossfading = out_xfade_r;

  assign span_w     = {1'b0, note_r} + {1'b0, rel_r};
  assign ad_w       = {1'b0, att_r} + {1'b0, dec_r};
  assign e_lt_span  = e_r < FW'(span_w);
  assign e_lt_att   = e_r < FW'(att_r);
  assign e_lt_ad    = e_r < FW'(ad_w);
  assign e_lt_note  = e_r < FW'(note_r);
  assign dec_k_w    = e_r[TW-1:0] - att_r;
  assign dec_rest_w = ad_w - e_r[TW:0];
  assign rel_rest_w = span_w - e_r[TW:0];
  assign att_dvd_w  = {1'b0, e_r[TW-1:0], {QW{1'b0}}};
  assign nsum_dvd_w = prod_r[DW-1:0] + {1'b0, tmp_r, {QW{1'b0}}};

  assign prod_w     = mul_a_r * mul_b_r;

  assign cnt_lim_w  = {1'b0, cfg_len_r};
  assign cnt_cap_w  = cnt_lim_w + CW'(1);
  assign cnt_adv_w  = (fade_cnt_r < cnt_cap_w) ? fade_cnt_r + CW'(1) : fade_cnt_r;
  assign blend_en   = fade_act_r && (cfg_len_r != '0) && (fade_cnt_r < cnt_lim_w);

  assign num_w      = acc_r + signed'(prod_r[XW-1:0]);
  assign num_abs_w  = num_w[XW-1] ? XW'(-num_w) : num_w;
  assign bl_dvd_w   = {{(DW-XW){1'b0}}, num_abs_w};

  assign dstep_t    = {div_rem_r, div_dq_r[NS-1]};
  assign dstep_ge   = dstep_t >= {1'b0, div_den_r};
  assign dstep_sub  = dstep_t - {1'b0, div_den_r};
  assign q_adj_w    = div_dq_r + NS'(div_rem_r != '0);
  assign q_neg_w    = NS'(0) - q_adj_w;

  // sequencer and envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_len_r   <= adsrxf_pkg::FADE_RESET;
      att_r       <= '0;
      dec_r       <= '0;
      rel_r       <= '0;
      note_r      <= '0;
      sus_r       <= '0;
      start_r     <= '0;
      gain_r      <= '0;
      fade_act_r  <= 1'b0;
      fade_cnt_r  <= '0;
      fade_from_r <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_len_r <= cfg_wdata;
      end
      out_valid_r <= out_load || (out_valid_r && out_stall);
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_command == adsrxf_pkg::CMD_TICK) begin
              state_r <= S_PHASE;
            end else begin
              fade_act_r  <= 1'b1;
              fade_cnt_r  <= '0;
              fade_from_r <= last_r;
              start_r     <= in_start_time;
              if (in_command != adsrxf_pkg::CMD_START) begin
                gain_r <= in_amplitude;
              end
              if (in_command == adsrxf_pkg::CMD_FULL) begin
                att_r  <= in_attack_time;
                dec_r  <= in_decay_time;
                rel_r  <= in_release_time;
                note_r <= in_note_length;
                sus_r  <= (in_sustain > adsrxf_pkg::ONE_Q) ? adsrxf_pkg::ONE_Q : in_sustain;
              end
            end
          end
        end
        S_PHASE: begin
          if (!(ge_r && e_lt_span) || (!e_lt_att && !e_lt_ad && e_lt_note)) begin
            state_r <= S_SCALE;
          end else if (e_lt_att) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_MW;
          end
        end
        S_MW:    state_r <= S_NSUM;
        S_NSUM:  state_r <= S_DIV;
        S_DIV: begin
          if (div_cnt_r == adsrxf_pkg::DIV_CNT_W'(NS - 1)) begin
            state_r <= S_DDONE;
          end
        end
        S_DDONE: state_r <= div_blend_r ? S_DONE : S_SCALE;
        S_SCALE: state_r <= S_SW;
        S_SW:    state_r <= S_VAL;
        S_VAL:   state_r <= blend_en ? S_B2 : S_DONE;
        S_B2:    state_r <= S_B3;
        S_B3:    state_r <= S_B4;
        S_B4:    state_r <= S_DIV;
        S_DONE: begin
          if (out_load) begin
            last_r      <= val_r;
            state_r     <= S_IDLE;
            if (fade_act_r) begin
              fade_cnt_r <= cnt_adv_w;
              if (cnt_adv_w > cnt_lim_w) begin
                fade_act_r <= 1'b0;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath: shared multiplier, shared divider, output word
  always_ff @(posedge clk) begin
    prod_r <= prod_w;
    if (out_load) begin
      out_level_r  <= val_r;
      out_in_env_r <= inside_r;
      out_xfade_r  <= fade_act_r;
    end
    unique case (state_r)
      S_IDLE: begin
        e_r  <= in_frame - start_r;
        ge_r <= in_frame >= start_r;
      end
      S_PHASE: begin
        inside_r    <= ge_r && e_lt_span;
        div_blend_r <= 1'b0;
        mul_b_r     <= {2'b00, sus_r};
        div_cnt_r   <= '0;
        if (!(ge_r && e_lt_span)) begin
          env_r <= '0;
        end else if (e_lt_att) begin
          div_den_r <= att_r;
          div_rem_r <= TW'(att_dvd_w[DW-1:NS]);
          div_dq_r  <= att_dvd_w[NS-1:0];
        end else if (e_lt_ad) begin
          mul_a_r   <= {1'b0, dec_k_w};
          tmp_r     <= dec_rest_w[TW-1:0];
          div_den_r <= dec_r;
        end else if (e_lt_note) begin
          env_r <= sus_r;
        end else begin
          mul_a_r   <= {1'b0, rel_rest_w[TW-1:0]};
          tmp_r     <= '0;
          div_den_r <= rel_r;
        end
      end
      S_NSUM: begin
        div_rem_r <= TW'(nsum_dvd_w[DW-1:NS]);
        div_dq_r  <= nsum_dvd_w[NS-1:0];
        div_cnt_r <= '0;
      end
      S_DIV: begin
        div_rem_r <= dstep_ge ? dstep_sub[TW-1:0] : dstep_t[TW-1:0];
        div_dq_r  <= {div_dq_r[NS-2:0], dstep_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      S_DDONE: begin
        if (div_blend_r) begin
          val_r <= neg_r ? q_neg_w[SW-1:0] : div_dq_r[SW-1:0];
        end else begin
          env_r <= div_dq_r[SW-1:0];
        end
      end
      S_SCALE: begin
        mul_a_r <= {{(AW-SW){1'b0}}, env_r};
        mul_b_r <= {{(BW-SW){gain_r[SW-1]}}, gain_r};
      end
      S_VAL: begin
        val_r   <= prod_r[QW+SW-1:QW];
        mul_a_r <= {{(AW-SW){prod_r[QW+SW-1]}}, prod_r[QW+SW-1:QW]};
        mul_b_r <= {1'b0, fade_cnt_r};
      end
      S_B2: begin
        mul_a_r <= {{(AW-SW){fade_from_r[SW-1]}}, fade_from_r};
        mul_b_r <= {1'b0, cnt_lim_w - fade_cnt_r};
      end
      S_B3: begin
        acc_r <= signed'(prod_r[XW-1:0]);
      end
      S_B4: begin
        neg_r       <= num_w[XW-1];
        div_blend_r <= 1'b1;
        div_den_r   <= TW'(cfg_len_r);
        div_rem_r   <= TW'(bl_dvd_w[DW-1:NS]);
        div_dq_r    <= bl_dvd_w[NS-1:0];
        div_cnt_r   <= '0;
      end
      default: begin
      end
    endcase
  end

  `ADSRXF_ASSERT_NEXT(a_tick_enters_phase, in_acc && in_command == adsrxf_pkg::CMD_TICK, state_r == S_PHASE, "tick word did not start the sequence")
  `ADSRXF_ASSERT_NEXT(a_retrigger_arms_fade, in_acc && in_command != adsrxf_pkg::CMD_TICK, fade_act_r && fade_cnt_r == '0 && state_r == S_IDLE, "retrigger did not arm the blend")
  `ADSRXF_ASSERT_SAME(a_div_count_bound, state_r == S_DIV, div_cnt_r < adsrxf_pkg::DIV_CNT_W'(NS), "divider ran past its last step")
  `ADSRXF_ASSERT_SAME(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE, "result word raised outside the final state")

endmodule

`default_nettype wire

FILE: tb/adsrxf_level_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adsrxf_level_checker
// watches the command and level channels of the envelope block, predicts each
// tick's level word from its own copy of the envelope state and compares the
// level words that come out, in order, field by field
// ----------------------------------------------------------------------------

module adsrxf_level_checker
  import adsrxf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  cmd_t                       in_command,
  input  logic [FRAME_W-1:0]         in_frame,
  input  logic [TIME_W-1:0]          in_attack_time,
  input  logic [TIME_W-1:0]          in_decay_time,
  input  logic [SAMPLE_W-1:0]        in_sustain,
  input  logic [TIME_W-1:0]          in_release_time,
  input  logic [FRAME_W-1:0]         in_start_time,
  input  logic [TIME_W-1:0]          in_note_length,
  input  logic signed [SAMPLE_W-1:0] in_amplitude,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_level,
  input  logic                       out_in_envelope,
  input  logic                       out_crossfading,
  input  logic                       cfg_we,
  input  logic [FADE_W-1:0]          cfg_wdata,
  output int                         errors,
  output int                         pending
);

  localparam longint unsigned UNITY = 64'(ONE_Q);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] level;
    logic                       in_env;
    logic                       fading;
  } level_t;

  logic [FADE_W-1:0]          xfade_len;
  logic [TIME_W-1:0]          attack_len;
  logic [TIME_W-1:0]          decay_len;
  logic [TIME_W-1:0]          release_len;
  logic [TIME_W-1:0]          note_len;
  logic [SAMPLE_W-1:0]        sustain_level;
  logic [FRAME_W-1:0]         start_frame;
  logic signed [SAMPLE_W-1:0] gain;
  logic                       fade_active;
  logic [CNT_W-1:0]           fade_count;
  logic signed [SAMPLE_W-1:0] fade_from;
  logic signed [SAMPLE_W-1:0] last_level;

  level_t level_q[$];
  int     mismatch_cnt = 0;

  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if (num % den != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic level_t next_level(input logic [FRAME_W-1:0] frame);
    longint unsigned e, env, k, a, d, s, r, n;
    longint val, span, c;
    level_t res;
    a = attack_len;
    d = decay_len;
    s = sustain_level;
    r = release_len;
    n = note_len;
    env = 0;
    res.in_env = 1'b0;
    res.fading = fade_active;
    if (frame >= start_frame) begin
      e = frame - start_frame;
      if (e < n + r) begin
        res.in_env = 1'b1;
        if (e < a) begin
          env = (e * UNITY) / a;
        end else if (e < a + d) begin
          k = e - a;
          env = (k * s + (d - k) * UNITY) / d;
        end else if (e < n) begin
          env = s;
        end else begin
          k = e - n;
          env = ((r - k) * s) / r;
        end
      end
    end
    val = floor_div(longint'(env) * longint'(gain), longint'(UNITY));
    if (fade_active) begin
      span = xfade_len;
      c = fade_count;
      if (span > 0 && c < span)
        val = floor_div(val * c + longint'(fade_from) * (span - c), span);
      if (c < span + 1) fade_count = fade_count + 1'b1;
      if (fade_count > xfade_len) fade_active = 1'b0;
    end
    last_level = val[SAMPLE_W-1:0];
    res.level = val[SAMPLE_W-1:0];
    return res;
  endfunction

  function automatic void start_fade();
    fade_active = 1'b1;
    fade_count = '0;
    fade_from = last_level;
  endfunction

  task automatic report(input bit orphan, input level_t want, input level_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      if (orphan)
        $display("%m: level word with none expected: level %0d env %0b xfade %0b",
                 got.level, got.in_env, got.fading);
      else
        $display("%m: expected level %0d env %0b xfade %0b, got level %0d env %0b xfade %0b",
                 want.level, want.in_env, want.fading, got.level, got.in_env, got.fading);
    end
  endtask

  always @(posedge clk) begin
    level_t got, want;
    if (!rst_n) begin
      xfade_len = FADE_RESET;
      attack_len = '0;
      decay_len = '0;
      release_len = '0;
      note_len = '0;
      sustain_level = '0;
      start_frame = '0;
      gain = '0;
      fade_active = 1'b0;
      fade_count = '0;
      fade_from = '0;
      last_level = '0;
      level_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.level = out_level;
        got.in_env = out_in_envelope;
        got.fading = out_crossfading;
        if (level_q.size() == 0) begin
          report(1'b1, got, got);
        end else begin
          want = level_q.pop_front();
          if (got.level !== want.level || got.in_env !== want.in_env ||
              got.fading !== want.fading)
            report(1'b0, want, got);
        end
      end
      if (cfg_we) xfade_len = cfg_wdata;
      if (in_valid && !in_stall) begin
        case (in_command)
          CMD_TICK: begin
            level_q.insert(level_q.size(), next_level(in_frame));
          end
          CMD_FULL: begin
            start_fade();
            attack_len = in_attack_time;
            decay_len = in_decay_time;
            sustain_level = (in_sustain > ONE_Q) ? ONE_Q : in_sustain;
            release_len = in_release_time;
            start_frame = in_start_time;
            note_len = in_note_length;
            gain = in_amplitude;
          end
          CMD_START_AMP: begin
            start_fade();
            start_frame = in_start_time;
            gain = in_amplitude;
          end
          default: begin
            start_fade();
            start_frame = in_start_time;
          end
        endcase
      end
    end
    pending <= level_q.size();
    errors <= mismatch_cnt;
  end

endmodule

FILE: tb/adsr_envelope_crossfade_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adsr_envelope_crossfade_tb
// drives command words into the envelope block: a directed pass over phase
// boundaries, zero lengths, extreme frames and gains and an over-range sustain,
// then random notes (retrigger plus ticks around its start) mixed with noise
// words, under several crossfade lengths; sender bursts and receiver stalls at
// random, with two long receiver hold-offs; the checker judges every level word
// ----------------------------------------------------------------------------

module adsr_envelope_crossfade_tb;
  import adsrxf_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 83;

  typedef struct packed {
    cmd_t                       cmd;
    logic [FRAME_W-1:0]         frame;
    logic [TIME_W-1:0]          attack_len;
    logic [TIME_W-1:0]          decay_len;
    logic [SAMPLE_W-1:0]        sustain;
    logic [TIME_W-1:0]          release_len;
    logic [FRAME_W-1:0]         start_frame;
    logic [TIME_W-1:0]          note_len;
    logic signed [SAMPLE_W-1:0] amp;
  } env_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  cmd_t                       in_command = CMD_TICK;
  logic [FRAME_W-1:0]         in_frame = '0;
  logic [TIME_W-1:0]          in_attack_time = '0;
  logic [TIME_W-1:0]          in_decay_time = '0;
  logic [SAMPLE_W-1:0]        in_sustain = '0;
  logic [TIME_W-1:0]          in_release_time = '0;
  logic [FRAME_W-1:0]         in_start_time = '0;
  logic [TIME_W-1:0]          in_note_length = '0;
  logic signed [SAMPLE_W-1:0] in_amplitude = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_level;
  logic                       out_in_envelope;
  logic                       out_crossfading;
  logic                       cfg_we = 1'b0;
  logic [FADE_W-1:0]          cfg_wdata = '0;

  int errors;
  int pending;
  int quiet = 0;
  int hold_seq = 0;
  int burst_left = 0;
  int sent = 0;
  logic [FRAME_W-1:0] cur_start = '0;
  int unsigned cur_span = 0;
  logic [FADE_W-1:0] fade_plan [PHASES];

  initial begin
    forever #5 clk = ~clk;
  end

  adsr_envelope_crossfade DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_frame        (in_frame),
    .in_attack_time  (in_attack_time),
    .in_decay_time   (in_decay_time),
    .in_sustain      (in_sustain),
    .in_release_time (in_release_time),
    .in_start_time   (in_start_time),
    .in_note_length  (in_note_length),
    .in_amplitude    (in_amplitude),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .out_in_envelope (out_in_envelope),
    .out_crossfading (out_crossfading),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  adsrxf_level_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_frame        (in_frame),
    .in_attack_time  (in_attack_time),
    .in_decay_time   (in_decay_time),
    .in_sustain      (in_sustain),
    .in_release_time (in_release_time),
    .in_start_time   (in_start_time),
    .in_note_length  (in_note_length),
    .in_amplitude    (in_amplitude),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .out_in_envelope (out_in_envelope),
    .out_crossfading (out_crossfading),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .errors          (errors),
    .pending         (pending)
  );

  function automatic env_word_t junk_word();
    env_word_t w;
    w.cmd = cmd_t'($urandom_range(0, 3));
    w.frame = $urandom();
    w.attack_len = TIME_W'($urandom());
    w.decay_len = TIME_W'($urandom());
    w.sustain = SAMPLE_W'($urandom_range(0, 32768));
    w.release_len = TIME_W'($urandom());
    w.start_frame = $urandom();
    w.note_len = TIME_W'($urandom());
    w.amp = SAMPLE_W'($urandom());
    return w;
  endfunction

  function automatic logic [TIME_W-1:0] pick_len();
    if ($urandom_range(0, 7) == 0) return TIME_W'($urandom());
    return TIME_W'($urandom_range(0, 40));
  endfunction

  // one word per call; valid stays up inside a burst
  task automatic put_word(input env_word_t w);
    longint unsigned sum;
    int gap;
    in_valid <= 1'b1;
    in_command <= w.cmd;
    in_frame <= w.frame;
    in_attack_time <= w.attack_len;
    in_decay_time <= w.decay_len;
    in_sustain <= w.sustain;
    in_release_time <= w.release_len;
    in_start_time <= w.start_frame;
    in_note_length <= w.note_len;
    in_amplitude <= w.amp;
    do @(posedge clk); while (in_stall);
    sent++;
    if (w.cmd != CMD_TICK) cur_start = w.start_frame;
    if (w.cmd == CMD_FULL) begin
      sum = 64'(w.attack_len) + w.decay_len + w.note_len + w.release_len;
      cur_span = (sum > 64'h0fff_ffff) ? 32'h0fff_ffff : 32'(sum);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_tick(input logic [FRAME_W-1:0] frame);
    env_word_t w;
    w = junk_word();
    w.cmd = CMD_TICK;
    w.frame = frame;
    put_word(w);
  endtask

  task automatic send_full(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] d,
                           input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] r,
                           input logic [FRAME_W-1:0] st, input logic [TIME_W-1:0] n,
                           input logic signed [SAMPLE_W-1:0] amp);
    env_word_t w;
    w = junk_word();
    w.cmd = CMD_FULL;
    w.attack_len = a;
    w.decay_len = d;
    w.sustain = s;
    w.release_len = r;
    w.start_frame = st;
    w.note_len = n;
    w.amp = amp;
    put_word(w);
  endtask

  task automatic send_restart(input cmd_t cmd, input logic [FRAME_W-1:0] st,
                              input logic signed [SAMPLE_W-1:0] amp);
    env_word_t w;
    w = junk_word();
    w.cmd = cmd;
    w.start_frame = st;
    w.amp = amp;
    put_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_fade(input logic [FADE_W-1:0] len);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // retrigger with random content, then ticks, most of them around the new start
  task automatic play_note();
    int pick, ticks;
    logic [FRAME_W-1:0] st;
    logic [SAMPLE_W-1:0] s;
    pick = $urandom_range(0, 9);
    st = ($urandom_range(0, 5) == 0) ? 32'hffff_ffff - $urandom_range(0, 200) : $urandom();
    s = ($urandom_range(0, 7) == 0) ? ONE_Q : SAMPLE_W'($urandom_range(0, 32768));
    if (pick < 6)
      send_full(pick_len(), pick_len(), s, pick_len(), st, pick_len(), SAMPLE_W'($urandom()));
    else if (pick < 8)
      send_restart(CMD_START_AMP, st, SAMPLE_W'($urandom()));
    else
      send_restart(CMD_START, st, SAMPLE_W'($urandom()));
    ticks = $urandom_range(2, 14);
    repeat (ticks) begin
      pick = $urandom_range(0, 7);
      if (pick == 0)
        send_tick(cur_start - $urandom_range(1, 5));
      else if (pick == 1)
        send_tick($urandom());
      else
        send_tick(cur_start + $urandom_range(0, cur_span + 4));
    end
  endtask

  // receiver stall patterns, with a long hold-off on request
  initial begin
    int hold_seen, seg_len, mode, phase;
    hold_seen = 0;
    phase = 0;
    @(posedge clk);
    forever begin
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg_len = $urandom_range(5, 60);
      mode = $urandom_range(0, 3);
      repeat (seg_len) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= ($urandom_range(0, 4) != 0);
          default: out_stall <= phase[0];
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("adsr_envelope_crossfade_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    fade_plan[0] = 16'd1;
    fade_plan[1] = 16'd65535;
    fade_plan[2] = 16'd2;
    fade_plan[3] = 16'd37;
    fade_plan[4] = FADE_W'($urandom_range(3, 400));
    fade_plan[5] = 16'd65535;
    fade_plan[6] = 16'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass, default crossfade length
    send_tick('0);
    send_tick('1);
    send_full(24'd4, 24'd4, 16'h4000, 24'd4, 32'd10, 24'd12, 16'sh7fff);
    send_tick(32'd9);
    send_tick(32'd10);
    send_tick(32'd12);
    send_tick(32'd14);
    send_tick(32'd18);
    send_tick(32'd22);
    send_tick(32'd25);
    send_tick(32'd26);
    send_restart(CMD_START_AMP, 32'hffff_fff0, 16'sh8000);
    send_tick(32'hffff_fff5);
    send_tick(32'hffff_ffff);
    send_restart(CMD_START, 32'd0, 16'sh0123);
    send_full('1, '1, 16'hffff, '1, 32'd0, '1, 16'shffff);
    send_tick(32'h00ff_fffe);
    send_tick(32'h0180_0000);
    send_tick(32'h01ff_fffd);
    send_full('0, '0, ONE_Q, '0, 32'd5, '0, 16'sh4000);
    send_tick(32'd5);
    // attack and decay run past the note end
    send_full(24'd10, 24'd10, 16'h9000, 24'd8, 32'd100, 24'd5, 16'sh8000);
    send_tick(32'd104);
    send_tick(32'd112);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_fade(fade_plan[p]);
      if (p == 1 || p == 4) hold_seq <= hold_seq + 1;
      while (sent < 24 + (p + 1) * PHASE_WORDS) begin
        if ($urandom_range(0, 3) == 0) put_word(junk_word());
        else play_note();
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    if (errors == 0 && pending == 0)
      $display("adsr_envelope_crossfade_tb: clean");
    else
      $display("adsr_envelope_crossfade_tb: errors");
    $finish;
  end

endmodule
